[hw/rtl/adc_deadband_change_notifier_macros.svh]
// ----------------------------------------------------------------------------
// Deadband change notifier assertion macros
// Property wrappers for the checks in the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ADC_DEADBAND_CHANGE_NOTIFIER_MACROS_SVH
`define ADC_DEADBAND_CHANGE_NOTIFIER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deadband notifier check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ADN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deadband notifier check failed");

`endif

[hw/rtl/adc_dbn_pkg.sv]
// ----------------------------------------------------------------------------
// Deadband change notifier package
// Shared constants, register codes, item types and mask helpers.
// ----------------------------------------------------------------------------
package adc_dbn_pkg;

	localparam int DEF_NUM_SLOTS = 16;
	localparam int NUM_CHANS     = 19;
	localparam int CHAN_W        = 5;
	localparam int VALUE_W       = 16;
	localparam int SLOT_W        = 4;
	localparam int COUNT_W       = 5;
	localparam int MASK_W        = 19;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [MASK_W-1:0] CHAN_MASK_BITS = 19'h7ffff;
	localparam logic [MASK_W-1:0] INTERNAL_CHANS = 19'h07000;

	localparam logic [MASK_W-1:0]  RST_CHANNEL_MASK  = 19'h000ff;
	localparam logic [VALUE_W-1:0] RST_DEADBAND      = 16'd7;
	localparam logic [VALUE_W-1:0] RST_IDLE_DEADBAND = 16'd0;
	localparam logic [VALUE_W-1:0] RST_IDLE_RELOAD   = 16'd0;

	typedef enum logic [1:0] {
		REG_CHANNEL_MASK  = 2'd0,
		REG_DEADBAND      = 2'd1,
		REG_IDLE_DEADBAND = 2'd2,
		REG_IDLE_RELOAD   = 2'd3
	} reg_idx_t;

	typedef enum logic {
		KIND_SAMPLE  = 1'b0,
		KIND_SERVICE = 1'b1
	} kind_t;

	typedef struct packed {
		logic [MASK_W-1:0]  channel_mask;
		logic [VALUE_W-1:0] deadband;
		logic [VALUE_W-1:0] idle_deadband;
		logic [VALUE_W-1:0] idle_reload;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic [SLOT_W-1:0]  slot;
		logic [VALUE_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Channels that can carry a slot: drop the internal ones.
	function automatic logic [MASK_W-1:0] eff_mask(input logic [MASK_W-1:0] m);
		return m & CHAN_MASK_BITS & ~INTERNAL_CHANS;
	endfunction

	// Number of slots that map to an enabled channel, capped.
	function automatic logic [COUNT_W-1:0] slot_count(input logic [MASK_W-1:0] m,
			input logic [COUNT_W-1:0] cap);
		logic [MASK_W-1:0]  e;
		logic [COUNT_W-1:0] n;
		e = eff_mask(m);
		n = '0;
		for (int i = 0; i < NUM_CHANS; i++) begin
			n = n + COUNT_W'(e[i]);
		end
		return (n > cap) ? cap : n;
	endfunction

endpackage

[hw/rtl/adc_dbn_front.sv]
// ----------------------------------------------------------------------------
// Deadband change notifier front end
// Accepts items, drops samples for slots without a channel, pushes the rest.
// ----------------------------------------------------------------------------
module adc_dbn_front #(
	parameter int NUM_SLOTS = adc_dbn_pkg::DEF_NUM_SLOTS
) (
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               kind,
	input  logic [adc_dbn_pkg::SLOT_W-1:0]     slot,
	input  logic [adc_dbn_pkg::VALUE_W-1:0]    sample_value,
	input  logic [adc_dbn_pkg::MASK_W-1:0]     channel_mask,
	input  logic                               q_full,
	output logic                               push,
	output adc_dbn_pkg::item_t                 push_item
);

	logic [adc_dbn_pkg::COUNT_W-1:0] n_slots;
	logic                            accept;
	logic                            keep;

	assign n_slots  = adc_dbn_pkg::slot_count(channel_mask,
		adc_dbn_pkg::COUNT_W'(NUM_SLOTS));
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Service items always go through; samples only for a mapped slot.
	assign keep = (adc_dbn_pkg::kind_t'(kind) == adc_dbn_pkg::KIND_SERVICE)
		|| ({1'b0, slot} < n_slots);

	assign push            = accept && keep;
	assign push_item.kind  = adc_dbn_pkg::kind_t'(kind);
	assign push_item.slot  = slot;
	assign push_item.value = sample_value;

endmodule

[hw/rtl/adc_dbn_fifo.sv]
// ----------------------------------------------------------------------------
// Deadband change notifier item queue
// Short first-in first-out queue between front end and back end.
// ----------------------------------------------------------------------------
module adc_dbn_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  adc_dbn_pkg::item_t    push_item,
	input  logic                  pop,
	output adc_dbn_pkg::item_t    pop_item,
	output adc_dbn_pkg::q_status_t status
);

	localparam int DEPTH = adc_dbn_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	adc_dbn_pkg::item_t mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_item     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[hw/rtl/adc_dbn_back.sv]
// ----------------------------------------------------------------------------
// Deadband change notifier back end
// Per-slot deadband update and ascending scan of flagged slots on service.
// ----------------------------------------------------------------------------
module adc_dbn_back #(
	parameter int NUM_SLOTS = adc_dbn_pkg::DEF_NUM_SLOTS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  adc_dbn_pkg::cfg_t               cfg,
	input  logic                            q_empty,
	input  adc_dbn_pkg::item_t              q_item,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [adc_dbn_pkg::CHAN_W-1:0]  channel_number,
	output logic [adc_dbn_pkg::VALUE_W-1:0] published_value,
	output logic                            last
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int VW    = adc_dbn_pkg::VALUE_W;
	localparam int CW    = adc_dbn_pkg::CHAN_W;
	localparam int NW    = adc_dbn_pkg::COUNT_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [VW-1:0]          pub_mem [NUM_SLOTS];
	logic [VW-1:0]          cnt_mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]   vld_q;
	logic [NUM_SLOTS-1:0]   flags_q;
	logic [NUM_SLOTS-1:0]   pend_q;
	logic [VW-1:0]          pub_rd_q;
	logic [VW-1:0]          cnt_rd_q;
	logic                   rd_vld_q;
	logic [IDX_W-1:0]       slot_q;
	logic [VW-1:0]          value_q;
	logic [CW-1:0]          chan_q;
	logic [NW-1:0]          rank_q;
	logic [CW-1:0]          emit_chan_q;
	logic                   emit_last_q;
	logic                   out_valid_q;
	logic [CW-1:0]          channel_number_q;
	logic [VW-1:0]          published_value_q;
	logic                   last_q;

	logic [adc_dbn_pkg::MASK_W-1:0] eff;
	logic [NW-1:0]          n_slots;
	logic [NUM_SLOTS-1:0]   low_mask;
	logic [NUM_SLOTS-1:0]   pend_clr;
	logic [IDX_W-1:0]       rank_idx;
	logic [IDX_W-1:0]       rd_idx;
	logic                   rd_en;
	logic                   scan_hit;
	logic [VW-1:0]          pub_v;
	logic [VW-1:0]          cnt_v;
	logic [VW-1:0]          diff;
	logic [VW-1:0]          band;
	logic                   publish;
	logic                   pub_we;
	logic                   cnt_we;
	logic [VW-1:0]          cnt_next;
	logic                   out_free;

	assign eff      = adc_dbn_pkg::eff_mask(cfg.channel_mask);
	assign n_slots  = adc_dbn_pkg::slot_count(cfg.channel_mask, NW'(NUM_SLOTS));
	assign rank_idx = rank_q[IDX_W-1:0];

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			low_mask[i] = (NW'(i) < n_slots);
			pend_clr[i] = pend_q[i] && (IDX_W'(i) != rank_idx);
		end
	end

	assign pop      = (state_q == ST_IDLE) && !q_empty;
	assign scan_hit = (state_q == ST_SCAN) && (pend_q != '0) && eff[chan_q]
		&& pend_q[rank_idx];
	assign rd_en    = (pop && (q_item.kind == adc_dbn_pkg::KIND_SAMPLE)) || scan_hit;
	assign rd_idx   = (state_q == ST_IDLE) ? q_item.slot[IDX_W-1:0] : rank_idx;

	// Entries never written read as zero.
	assign pub_v = rd_vld_q ? pub_rd_q : '0;
	assign cnt_v = rd_vld_q ? cnt_rd_q : '0;

	assign diff    = (value_q > pub_v) ? (value_q - pub_v) : (pub_v - value_q);
	assign band    = ((cnt_v != '0) || (cfg.idle_deadband == '0)) ? cfg.deadband
		: cfg.idle_deadband;
	assign publish = diff > band;

	assign pub_we   = (state_q == ST_EXEC) && publish;
	assign cnt_we   = (state_q == ST_EXEC) && (publish || (cnt_v != '0));
	assign cnt_next = publish ? cfg.idle_reload : (cnt_v - VW'(1));

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (pub_we) begin
			pub_mem[slot_q] <= value_q;
		end
		if (cnt_we) begin
			cnt_mem[slot_q] <= cnt_next;
		end
		if (rd_en) begin
			pub_rd_q <= pub_mem[rd_idx];
			cnt_rd_q <= cnt_mem[rd_idx];
			rd_vld_q <= vld_q[rd_idx];
		end
		if (pop) begin
			slot_q  <= q_item.slot[IDX_W-1:0];
			value_q <= q_item.value;
		end
		if (scan_hit) begin
			emit_chan_q <= chan_q;
			emit_last_q <= (pend_clr == '0);
		end
		if ((state_q == ST_EMIT) && out_free) begin
			channel_number_q  <= emit_chan_q;
			published_value_q <= pub_v;
			last_q            <= emit_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vld_q       <= '0;
			flags_q     <= '0;
			pend_q      <= '0;
			chan_q      <= '0;
			rank_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a new report, or drop the one just taken.
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (q_item.kind == adc_dbn_pkg::KIND_SERVICE) begin
							// Snapshot the flags of mapped slots and clear them all.
							pend_q  <= flags_q & low_mask;
							flags_q <= '0;
							chan_q  <= '0;
							rank_q  <= '0;
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					if (publish) begin
						vld_q[slot_q]   <= 1'b1;
						flags_q[slot_q] <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (pend_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						if (eff[chan_q]) begin
							rank_q <= rank_q + NW'(1);
						end
						chan_q <= chan_q + CW'(1);
						if (scan_hit) begin
							pend_q  <= pend_clr;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_SCAN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign channel_number  = channel_number_q;
	assign published_value = published_value_q;
	assign last            = last_q;

endmodule

[hw/rtl/adc_deadband_change_notifier.sv]
// Sample item: the back end reads the slot store, then compares and writes.
// Service item: channels are scanned upward to the highest flagged one (at most 19), one report
// per flagged slot; reports leave through a one-entry output register.
// A two-entry queue sits between front end and back end; in_ready drops only when full.
// Reset clears flags, per-slot valid bits and control registers at once; no clearing pass.
// ----------------------------------------------------------------------------
// Deadband change notifier top level
// Configuration registers, front end, item queue and back end.
// ----------------------------------------------------------------------------
`include "adc_deadband_change_notifier_macros.svh"

module adc_deadband_change_notifier #(
	parameter int NUM_SLOTS = adc_dbn_pkg::DEF_NUM_SLOTS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            kind,
	input  logic [adc_dbn_pkg::SLOT_W-1:0]  slot,
	input  logic [adc_dbn_pkg::VALUE_W-1:0] sample_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [adc_dbn_pkg::CHAN_W-1:0]  channel_number,
	output logic [adc_dbn_pkg::VALUE_W-1:0] published_value,
	output logic                            last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [adc_dbn_pkg::MASK_W-1:0]  cfg_data
);

	adc_dbn_pkg::cfg_t      cfg_q;
	adc_dbn_pkg::item_t     push_item;
	adc_dbn_pkg::item_t     pop_item;
	adc_dbn_pkg::q_status_t q_stat;
	logic                   q_push;
	logic                   q_pop;
	logic                   chan_ok;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_mask  <= adc_dbn_pkg::RST_CHANNEL_MASK;
			cfg_q.deadband      <= adc_dbn_pkg::RST_DEADBAND;
			cfg_q.idle_deadband <= adc_dbn_pkg::RST_IDLE_DEADBAND;
			cfg_q.idle_reload   <= adc_dbn_pkg::RST_IDLE_RELOAD;
		end else if (cfg_valid && cfg_ready) begin
			unique case (adc_dbn_pkg::reg_idx_t'(cfg_index))
				adc_dbn_pkg::REG_CHANNEL_MASK:
					cfg_q.channel_mask <= cfg_data & adc_dbn_pkg::CHAN_MASK_BITS;
				adc_dbn_pkg::REG_DEADBAND:
					cfg_q.deadband <= cfg_data[adc_dbn_pkg::VALUE_W-1:0];
				adc_dbn_pkg::REG_IDLE_DEADBAND:
					cfg_q.idle_deadband <= cfg_data[adc_dbn_pkg::VALUE_W-1:0];
				adc_dbn_pkg::REG_IDLE_RELOAD:
					cfg_q.idle_reload <= cfg_data[adc_dbn_pkg::VALUE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	adc_dbn_front #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.slot        (slot),
		.sample_value(sample_value),
		.channel_mask(cfg_q.channel_mask),
		.q_full      (q_stat.full),
		.push        (q_push),
		.push_item   (push_item)
	);

	adc_dbn_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(push_item),
		.pop      (q_pop),
		.pop_item (pop_item),
		.status   (q_stat)
	);

	adc_dbn_back #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_empty        (q_stat.empty),
		.q_item         (pop_item),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.channel_number (channel_number),
		.published_value(published_value),
		.last           (last)
	);

	// Reported channels exist and are never internal ones.
	assign chan_ok = (channel_number < 5'd19)
		&& !((channel_number >= 5'd12) && (channel_number <= 5'd14));

	`ADN_ASSERT_IMPL(a_chan_legal, clk, arst_n, out_valid, chan_ok)
	`ADN_ASSERT_IMPL(a_no_overflow, clk, arst_n, q_push, !q_stat.full)
	`ADN_ASSERT_IMPL(a_no_underflow, clk, arst_n, q_pop, !q_stat.empty)
	`ADN_ASSERT_NEXT(a_push_holds, clk, arst_n, q_push && !q_pop, !q_stat.empty)

endmodule
